FILE: hw/rtl/mipbox_pkg.sv
// Shared constants, types and helpers of the 2x2 mipmap box filter.
// Used by the lane, line buffer and top-level modules.
`default_nettype none

package mipbox_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MAX_CHANNELS = 4;

    localparam int NUM_LANES  = 4;
    localparam int CHAN_W     = 8;
    localparam int PAIR_W     = CHAN_W + 1;
    localparam int DIM_W      = 13;
    localparam int CCNT_W     = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int LINE_DW    = PAIR_W * NUM_LANES;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CHAN_COUNT = 2'd2;

    typedef struct packed {
        logic load;
        logic sw_one;
        logic sh_one;
    } mipbox_lane_ctl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [DIM_W-2:0] half_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-2:0] h;
        h = v[DIM_W-1:1];
        if (h == '0)
            h = (DIM_W-1)'(1);
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mipbox_lane.sv
// One channel lane: horizontal pair sum, then vertical sum and divide by 4.
// Depends on mipbox_pkg.
`default_nettype none

module mipbox_lane
    import mipbox_pkg::*;
(
    input  wire logic                 clk,
    input  wire mipbox_lane_ctl_t     ctl,
    input  wire logic [CHAN_W-1:0]    px,
    input  wire logic [CHAN_W-1:0]    left,
    input  wire logic [PAIR_W-1:0]    line_q,
    output logic      [PAIR_W-1:0]    pair_next,
    output logic      [CHAN_W-1:0]    avg
);

    logic [PAIR_W-1:0] pair_reg;
    logic [PAIR_W:0]   sum;

    always_comb
    begin
        if (ctl.sw_one)
            pair_next = {px, 1'b0};
        else
            pair_next = {1'b0, left} + {1'b0, px};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            pair_reg <= pair_next;
    end

    always_comb
    begin
        if (ctl.sh_one)
            sum = {pair_reg, 1'b0};
        else
            sum = {1'b0, line_q} + {1'b0, pair_reg};
        avg = sum[PAIR_W:2];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mipbox_line_buf.sv
// Line buffer of even-row pair sums, one access per beat, registered read.
// Depends on mipbox_pkg.
`default_nettype none

module mipbox_line_buf
    import mipbox_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic               re,
    input  wire logic [LINE_AW-1:0] addr,
    input  wire logic [LINE_DW-1:0] wdata,
    output logic      [LINE_DW-1:0] rdata
);

    logic [LINE_DW-1:0] mem [LINE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mipbox_top.sv
// Top level of the 2x2 mipmap box filter: APB registers, raster counters,
// four channel lanes, line buffer and the output register.
// Depends on mipbox_pkg, mipbox_lane and mipbox_line_buf.
//
//  channel   handshake             payload
//  in        in_valid / in_stall   chan0_in..chan3_in
//  out       out_valid / out_stall chan0_out..chan3_out, last_pixel
//  cfg       psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// One source pixel is taken every cycle while in_stall is low; a result is held in
// the pair stage and registered line buffer read, then in the output register.
// The line buffer needs no clearing after reset; counters reset to the level start.
// in_stall rises only while both the pair stage and the output register are full
// and out_stall is high.
`default_nettype none

module mipmap_box_downsample_top
    import mipbox_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CHAN_W-1:0] chan0_in,
    input  wire logic [CHAN_W-1:0] chan1_in,
    input  wire logic [CHAN_W-1:0] chan2_in,
    input  wire logic [CHAN_W-1:0] chan3_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [CHAN_W-1:0] chan0_out,
    output logic      [CHAN_W-1:0] chan1_out,
    output logic      [CHAN_W-1:0] chan2_out,
    output logic      [CHAN_W-1:0] chan3_out,
    output logic                   last_pixel
);

    logic [DIM_W-1:0]  src_width_reg;
    logic [DIM_W-1:0]  src_height_reg;
    logic [CCNT_W-1:0] chan_count_reg;
    logic              cfg_we;
    logic              cfg_restart;
    logic [1:0]        cfg_idx;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CHAN_W-1:0] left_reg [NUM_LANES];

    logic [DIM_W-1:0]  sw_c, sh_c;
    logic [DIM_W-2:0]  ow, oh;
    logic [DIM_W-1:0]  two_ow, two_oh;
    logic [CCNT_W-1:0] nc;
    logic              sw_one, sh_one;
    logic              have_pair, row_in, emit, line_we, line_re, last_cur;
    logic [LINE_AW-1:0] ox;
    logic [DIM_W-2:0]  oy;
    logic [DIM_W-1:0]  col_inc, row_inc;

    logic              accept, advance;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg;
    logic              s1_sh_one_reg;

    logic              out_valid_reg;
    logic [CHAN_W-1:0] out_chan_reg [NUM_LANES];
    logic              out_last_reg;

    logic [CHAN_W-1:0] px       [NUM_LANES];
    logic [PAIR_W-1:0] pair_nx  [NUM_LANES];
    logic [CHAN_W-1:0] avg      [NUM_LANES];
    logic [LINE_DW-1:0] line_wdata, line_rdata;
    mipbox_lane_ctl_t  lane_ctl;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_restart = cfg_we
                         && (cfg_idx inside {REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_CHAN_COUNT});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_W'(1);
            src_height_reg <= DIM_W'(1);
            chan_count_reg <= CCNT_W'(4);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[DIM_W-1:0];
                REG_CHAN_COUNT: chan_count_reg <= pwdata[CCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SRC_WIDTH:  prdata = APB_DW'(src_width_reg);
            REG_SRC_HEIGHT: prdata = APB_DW'(src_height_reg);
            REG_CHAN_COUNT: prdata = APB_DW'(chan_count_reg);
            default:        prdata = '0;
        endcase
    end

    assign px[0] = chan0_in;
    assign px[1] = chan1_in;
    assign px[2] = chan2_in;
    assign px[3] = chan3_in;

    always_comb
    begin
        sw_c   = clamp_dim(src_width_reg, DIM_W'(MAX_WIDTH));
        sh_c   = clamp_dim(src_height_reg, DIM_W'(MAX_HEIGHT));
        ow     = half_dim(sw_c);
        oh     = half_dim(sh_c);
        two_ow = {ow, 1'b0};
        two_oh = {oh, 1'b0};
        sw_one = (sw_c == DIM_W'(1));
        sh_one = (sh_c == DIM_W'(1));
        if (chan_count_reg == '0)
            nc = CCNT_W'(1);
        else if (chan_count_reg > CCNT_W'(MAX_CHANNELS))
            nc = CCNT_W'(MAX_CHANNELS);
        else
            nc = chan_count_reg;

        have_pair = sw_one || (col_reg[0] && (DIM_W'(col_reg) < two_ow));
        row_in    = DIM_W'(row_reg) < two_oh;
        emit      = have_pair && (sh_one || (row_reg[0] && row_in));
        line_we   = have_pair && !sh_one && !row_reg[0] && row_in;
        line_re   = emit && !sh_one;
        ox        = col_reg[COL_W-1:1];
        oy        = sh_one ? '0 : (DIM_W-1)'(row_reg[ROW_W-1:1]);
        last_cur  = ((DIM_W-1)'(ox) == ow - 1'b1) && (oy == oh - 1'b1);

        col_inc = DIM_W'(col_reg) + 1'b1;
        row_inc = DIM_W'(row_reg) + 1'b1;
        if (col_inc >= sw_c)
        begin
            col_next = '0;
            if (row_inc >= sh_c)
                row_next = '0;
            else
                row_next = row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end
    end

    assign advance       = !out_valid_reg || !out_stall;
    assign in_stall      = s1_valid_reg && !advance;
    assign accept        = in_valid && !in_stall;
    assign s1_valid_next = (s1_valid_reg && !advance) || (accept && emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LANES; i++)
                left_reg[i] <= '0;
        end
        else if (accept && !sw_one && !col_reg[0])
        begin
            for (int i = 0; i < NUM_LANES; i++)
                left_reg[i] <= px[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            s1_last_reg   <= last_cur;
            s1_sh_one_reg <= sh_one;
        end
    end

    assign lane_ctl.load   = accept && emit;
    assign lane_ctl.sw_one = sw_one;
    assign lane_ctl.sh_one = s1_sh_one_reg;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        mipbox_lane u_lane (
            .clk       (clk),
            .ctl       (lane_ctl),
            .px        (px[g]),
            .left      (left_reg[g]),
            .line_q    (line_rdata[g*PAIR_W +: PAIR_W]),
            .pair_next (pair_nx[g]),
            .avg       (avg[g])
        );
        assign line_wdata[g*PAIR_W +: PAIR_W] = pair_nx[g];
    end

    mipbox_line_buf u_line (
        .clk   (clk),
        .we    (accept && line_we),
        .re    (accept && line_re),
        .addr  (ox),
        .wdata (line_wdata),
        .rdata (line_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            for (int i = 0; i < NUM_LANES; i++)
                out_chan_reg[i] <= (CCNT_W'(i) < nc) ? avg[i] : '0;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign chan0_out  = out_chan_reg[0];
    assign chan1_out  = out_chan_reg[1];
    assign chan2_out  = out_chan_reg[2];
    assign chan3_out  = out_chan_reg[3];
    assign last_pixel = out_last_reg;

`ifndef ASSERT_OFF
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(col_reg) < sw_c)
        else $error("column counter beyond source width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(row_reg) < sh_c)
        else $error("row counter beyond source height");

    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !s1_valid_reg) |=> !out_valid_reg)
        else $error("result repeated after delivery");

    a_line_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && line_we && line_re))
        else $error("line buffer read and written by one beat");
`endif

endmodule

`default_nettype wire
